[hdl/piq_pkg.sv]
// shared types and codes for the positional insert queue
package piq_pkg;

	// width of the broadcast slot index, matches the request position field
	localparam int unsigned POS_W = 8;

	// result status codes
	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// per-cycle operation seen by every cell
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_POP
	} cell_op_t;

	// control broadcast along the chain
	typedef struct packed {
		cell_op_t         op;
		logic [POS_W-1:0] slot;
	} cell_ctrl_t;

endpackage

[hdl/piq_cell.sv]
// one storage cell of the queue chain, front of the queue is cell zero
module piq_cell import piq_pkg::*; #(
	parameter int unsigned ENTRY_WIDTH = 32,
	parameter int unsigned INDEX       = 0
) (
	input  logic                   clk,
	input  cell_ctrl_t             ctrl,
	input  logic [ENTRY_WIDTH-1:0] new_word,
	input  logic [ENTRY_WIDTH-1:0] prev_word,
	input  logic [ENTRY_WIDTH-1:0] next_word,
	output logic [ENTRY_WIDTH-1:0] word
);

	localparam logic [POS_W-1:0] MY_SLOT = POS_W'(INDEX);

	logic [ENTRY_WIDTH-1:0] word_q;
	logic [ENTRY_WIDTH-1:0] word_d;

	// select hold, load, take from front neighbor or take from back neighbor
	always_comb begin
		word_d = word_q;
		case (ctrl.op)
			OP_INSERT: begin
				if (ctrl.slot == MY_SLOT) begin
					word_d = new_word;
				end else if (ctrl.slot < MY_SLOT) begin
					word_d = prev_word;
				end
			end
			OP_POP: begin
				word_d = next_word;
			end
			default: begin
				word_d = word_q;
			end
		endcase
	end

	// slot storage
	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

	assign word = word_q;

endmodule

[hdl/positional_insert_queue.sv]
// top level of the positional insert queue
//
// A bounded queue of up to DEPTH entries kept in a chain of cells, front at
// cell zero. Requests arrive on in_valid/in_ready with req_type, position
// and entry_word. An insert (req_type 0) places entry_word at the 1-based
// position counted from the front, position 0 acting as 1 and positions
// beyond the fill level appending at the back; a full queue drops it with
// status 1. A pop (req_type 1) removes the front entry and returns it with
// out_valid set; an empty queue answers status 2.
// Every request yields one result transaction on result_valid/result_ready
// carrying out_valid, out_entry, status and fill_level (count afterwards).
// The result is registered in the cycle after the request is taken; all cells shift in
// the same cycle, so one request is taken every cycle while results drain.
// The single output register stalls the request side only while a result
// waits and result_ready is low.
// Reset clears the fill level and the pending result; cell contents are
// left unknown and are never read before being written.
module positional_insert_queue import piq_pkg::*; #(
	parameter int unsigned DEPTH       = 16,
	parameter int unsigned ENTRY_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [7:0]  position,
	input  logic [31:0] entry_word,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        out_valid,
	output logic [31:0] out_entry,
	output logic [1:0]  status,
	output logic [4:0]  fill_level
);

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
	// wide enough for position + 1 and any count
	localparam int unsigned PW = (CW > POS_W) ? CW + 1 : POS_W + 1;

	logic [CW-1:0]          count_q;
	logic                   res_valid_q;
	logic                   out_valid_q;
	logic [31:0]            out_entry_q;
	status_t                status_q;
	logic [CW-1:0]          count_d;
	logic                   in_fire;
	logic                   is_full;
	logic                   is_empty;
	logic [PW-1:0]          pos_eff;
	logic [PW-1:0]          count_ext;
	logic [PW-1:0]          ins_slot;
	cell_ctrl_t             ctrl;
	logic [ENTRY_WIDTH-1:0] new_word;
	logic [ENTRY_WIDTH-1:0] slot_w [DEPTH];

	// handshake, the output register frees when taken
	assign in_ready = !res_valid_q || result_ready;
	assign in_fire  = in_valid && in_ready;
	assign is_full  = (count_q == FULL_COUNT);
	assign is_empty = (count_q == '0);

	// clamp the insert position to the front and to the back of the queue
	assign pos_eff   = (position == 8'd0) ? PW'(1) : PW'(position);
	assign count_ext = PW'(count_q);
	assign ins_slot  = (pos_eff > count_ext) ? count_ext : (pos_eff - PW'(1));
	assign new_word  = ENTRY_WIDTH'(entry_word);

	// operation broadcast to the chain
	always_comb begin
		ctrl.op   = OP_HOLD;
		ctrl.slot = POS_W'(ins_slot);
		count_d   = count_q;
		if (in_fire) begin
			if (req_type) begin
				if (!is_empty) begin
					ctrl.op = OP_POP;
					count_d = count_q - CW'(1);
				end
			end else if (!is_full) begin
				ctrl.op = OP_INSERT;
				count_d = count_q + CW'(1);
			end
		end
	end

	// chain of cells, each linked to its front and back neighbors
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [ENTRY_WIDTH-1:0] prev_word;
		logic [ENTRY_WIDTH-1:0] next_word;
		if (i == 0) begin : g_front
			assign prev_word = '0;
		end else begin : g_mid_front
			assign prev_word = slot_w[i-1];
		end
		if (i == DEPTH - 1) begin : g_back
			assign next_word = '0;
		end else begin : g_mid_back
			assign next_word = slot_w[i+1];
		end
		piq_cell #(
			.ENTRY_WIDTH(ENTRY_WIDTH),
			.INDEX      (i)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.new_word (new_word),
			.prev_word(prev_word),
			.next_word(next_word),
			.word     (slot_w[i])
		);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (in_fire) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			out_valid_q <= 1'b0;
			out_entry_q <= '0;
			status_q    <= ST_DONE;
			if (req_type) begin
				if (is_empty) begin
					status_q <= ST_EMPTY;
				end else begin
					out_valid_q <= 1'b1;
					out_entry_q <= 32'(slot_w[0]);
				end
			end else if (is_full) begin
				status_q <= ST_FULL;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign out_valid    = out_valid_q;
	assign out_entry    = out_entry_q;
	assign status       = status_q;
	assign fill_level   = 5'(count_q);

`ifndef SYNTHESIS
	// fill level never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("queue count above depth");

	// a pop on a non-empty queue returns an entry and shrinks the queue
	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && req_type && !is_empty |=>
			res_valid_q && out_valid_q && status_q == ST_DONE &&
			count_q == $past(count_q) - CW'(1))
		else $error("pop result or count wrong");

	// an insert into a full queue is dropped without touching the count
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !req_type && is_full |=>
			status_q == ST_FULL && !out_valid_q && $stable(count_q))
		else $error("full insert not dropped");
`endif

endmodule

[tb/sv/positional_insert_queue_tb.sv]
// self-checking testbench for the positional insert queue
module positional_insert_queue_tb import piq_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH         = 16;
	localparam int unsigned ENTRY_WIDTH   = 32;
	localparam bit          REQ_INSERT    = 1'b0;
	localparam bit          REQ_POP       = 1'b1;
	localparam int          RANDOM_ITEMS  = 1600;
	localparam int          TAIL_ITEMS    = 150;
	localparam int          SETTLE_CYCLES = 8;
	localparam int          STALL_LIMIT   = 1000;

	typedef struct {
		bit       req_type;
		bit [7:0] position;
		bit [31:0] entry_word;
		bit       wait_drain;
	} request_t;

	typedef struct {
		bit        out_valid;
		bit [31:0] out_entry;
		status_t   status;
		bit [4:0]  fill_level;
	} pop_result_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        in_ready;
	logic        req_type     = REQ_INSERT;
	logic [7:0]  position     = '0;
	logic [31:0] entry_word   = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic        out_valid;
	logic [31:0] out_entry;
	logic [1:0]  status;
	logic [4:0]  fill_level;

	request_t    request_backlog[$];
	pop_result_t awaited_results[$];
	bit [31:0]   held_entries[$];
	int          errors       = 0;
	int          send_gap     = 0;
	int          send_stretch = 0;
	int          send_rate    = 0;
	int          recv_stall   = 0;
	int          recv_stretch = 0;
	int          recv_rate    = 0;
	int          quiet_cycles = 0;

	positional_insert_queue #(
		.DEPTH(DEPTH),
		.ENTRY_WIDTH(ENTRY_WIDTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.position(position),
		.entry_word(entry_word),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.out_valid(out_valid),
		.out_entry(out_entry),
		.status(status),
		.fill_level(fill_level)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// no idling once the stimulus is nearly used up
	function automatic bit in_tail();
		return request_backlog.size() < TAIL_ITEMS;
	endfunction

	// queue model: apply one request to the held entries and give its result
	function automatic pop_result_t apply_request(request_t req);
		pop_result_t res;
		int unsigned slot;
		res.out_valid = 1'b0;
		res.out_entry = '0;
		res.status    = ST_DONE;
		if (req.req_type == REQ_POP) begin
			if (held_entries.size() == 0) begin
				res.status = ST_EMPTY;
			end else begin
				res.out_valid = 1'b1;
				res.out_entry = held_entries.pop_front();
			end
		end else if (held_entries.size() >= DEPTH) begin
			res.status = ST_FULL;
		end else begin
			// position zero means the front, anything past the count appends
			slot = (req.position == 0) ? 1 : req.position;
			if (slot > held_entries.size())
				held_entries.push_back(req.entry_word);
			else
				held_entries.insert(slot - 1, req.entry_word);
		end
		res.fill_level = 5'(held_entries.size());
		return res;
	endfunction

	function automatic void add_request(bit kind, bit [7:0] pos, bit [31:0] word,
			bit drain = 1'b0);
		request_t req;
		req.req_type   = kind;
		req.position   = pos;
		req.entry_word = word;
		req.wait_drain = drain;
		request_backlog.push_back(req);
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			errors++;
		end
	endtask

	// request driver, fed from the backlog
	always @(posedge clk) begin
		request_t nxt;
		bit       taken;
		taken = in_valid && in_ready;
		if (arst_n && !(in_valid && !taken)) begin
			// idling changes character from stretch to stretch
			if (send_stretch == 0) begin
				send_stretch = $urandom_range(40, 300);
				case ($urandom_range(0, 2))
					0: send_rate = 0;
					1: send_rate = 3;
					default: send_rate = 12;
				endcase
			end else begin
				send_stretch--;
			end
			if (taken && !in_tail() && send_rate != 0 && $urandom_range(0, send_rate) == 0)
				send_gap = $urandom_range(1, 16);
			if (send_gap != 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (request_backlog.size() != 0 &&
					!(request_backlog[0].wait_drain &&
					(taken || awaited_results.size() != 0))) begin
				nxt = request_backlog.pop_front();
				in_valid   <= 1'b1;
				req_type   <= nxt.req_type;
				position   <= nxt.position;
				entry_word <= nxt.entry_word;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result side backpressure in random bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (recv_stretch == 0) begin
				recv_stretch = $urandom_range(40, 300);
				case ($urandom_range(0, 2))
					0: recv_rate = 0;
					1: recv_rate = 3;
					default: recv_rate = 12;
				endcase
			end else begin
				recv_stretch--;
			end
			if (recv_stall != 0) begin
				recv_stall--;
				result_ready <= 1'b0;
			end else if (!in_tail() && recv_rate != 0 && $urandom_range(0, recv_rate) == 0) begin
				recv_stall = $urandom_range(1, 16) - 1;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// monitor: check result transactions, then predict accepted requests
	always @(posedge clk) begin
		pop_result_t want;
		request_t    req;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (awaited_results.size() == 0) begin
					$error("unexpected result transaction: out_entry %0h status %0d",
						out_entry, status);
					errors++;
				end else begin
					want = awaited_results.pop_front();
					check_field("out_valid", want.out_valid, out_valid);
					check_field("out_entry", want.out_entry, out_entry);
					check_field("status", want.status, status);
					check_field("fill_level", want.fill_level, fill_level);
				end
			end
			if (in_valid && in_ready) begin
				req.req_type   = req_type;
				req.position   = position;
				req.entry_word = entry_word;
				req.wait_drain = 1'b0;
				awaited_results.push_back(apply_request(req));
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (result_valid && result_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$error("no transaction for %0d cycles", quiet_cycles);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// stimulus, reset and end of test
	initial begin
		int        phase_left;
		int        pop_pct;
		bit        kind;
		bit [7:0]  pos;
		bit [31:0] word;
		phase_left = 0;
		pop_pct    = 50;

		// directed: empty pop, front/middle/back inserts, fill to full, drops, pops
		add_request(REQ_POP, 8'd0, 32'h0);
		add_request(REQ_INSERT, 8'd0, 32'h0000_0000);
		add_request(REQ_INSERT, 8'hFF, 32'hFFFF_FFFF);
		add_request(REQ_INSERT, 8'd1, 32'hAAAA_AAAA);
		add_request(REQ_INSERT, 8'd2, 32'h5555_5555);
		add_request(REQ_INSERT, 8'd4, 32'h1234_5678);
		add_request(REQ_INSERT, 8'd6, 32'h8765_4321);
		for (int i = 0; i < 10; i++)
			add_request(REQ_INSERT, 8'((i * 5) % 9), $urandom);
		add_request(REQ_INSERT, 8'd1, 32'hDEAD_BEEF);
		add_request(REQ_INSERT, 8'hFF, 32'hFFFF_FFFF);
		add_request(REQ_POP, 8'hFF, 32'hFFFF_FFFF, 1'b1);
		for (int i = 0; i < 4; i++)
			add_request(REQ_POP, 8'd0, 32'h0);
		add_request(REQ_INSERT, 8'd0, 32'h0F0F_0F0F);

		// random: phases that lean toward filling, draining or neither
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(20, 80);
				case ($urandom_range(0, 2))
					0: pop_pct = 20;
					1: pop_pct = 50;
					default: pop_pct = 80;
				endcase
			end
			phase_left--;
			kind = ($urandom_range(0, 99) < pop_pct) ? REQ_POP : REQ_INSERT;
			case ($urandom_range(0, 9))
				0: pos = 8'd0;
				1: pos = 8'hFF;
				2, 3, 4, 5: pos = 8'($urandom_range(1, DEPTH + 1));
				default: pos = 8'($urandom);
			endcase
			case ($urandom_range(0, 15))
				0: word = '0;
				1: word = '1;
				default: word = $urandom;
			endcase
			add_request(kind, pos, word, (n % 400) == 399);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// sample between edges so the driver and monitor updates have settled
		while (request_backlog.size() != 0 || in_valid)
			@(negedge clk);
		while (awaited_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
